// File: rtl/assert_macros.svh
// Assertion macros shared by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/ukrt_pkg.sv
// Package with the constants, codes and types of the keyed record table.
package ukrt_pkg;
    localparam int Depth    = 64;
    localparam int Slots    = 5;
    localparam int AddrW    = $clog2(Depth);
    localparam int CntW     = AddrW + 1;
    localparam int KeyW     = 16;
    localparam int ScoreW   = 10;
    localparam int SlotW    = 16;
    localparam int RecW     = KeyW + ScoreW + Slots * SlotW;
    localparam int MatchW   = 9;
    localparam int OccW     = 7;
    localparam logic [ScoreW-1:0] ScoreMax = 10'd1000;
    localparam logic [MatchW-1:0] MatchMax = 9'd511;

    typedef enum logic [2:0] {
        F_INSERT = 3'd0, F_LOOKUP = 3'd1, F_DELETE = 3'd2, F_CHKEY = 3'd3,
        F_SETSC = 3'd4, F_SETSL = 3'd5, F_COUNT = 3'd6, F_NOP = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_FULL = 3'd1, ST_DUP = 3'd2, ST_NOT_FOUND = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_WAIT, S_SCAN2, S_SCAN2_WAIT, S_WRITE,
        S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_COUNT, S_COUNT_WAIT, S_DONE
    } t_state;
endpackage

// File: rtl/unique_key_record_table.sv
// Top level of the keyed record table with compacting delete.
// Usage: drive the operation fields and pulse start while busy is low; the
// transfer is taken at that edge and busy rises at once. Exactly one result
// appears later for one cycle with o_valid high; it must be captured then,
// as the receiver cannot hold it off.
// All records sit in one RAM (one record per word, registered read), swept
// by a small sequencer. A keyed search reads one entry at a time, issuing
// the read in S_SCAN and comparing it in S_SCAN_WAIT. Change key runs a second
// full search for the new key. Delete searches and then moves every later
// record down one place, through a read, a wait and a write state per record.
// Count visits each record once and compares its slots in parallel. A new
// request is taken only once the sequencer is back in idle.
// Reset clears the record count and the sequencer; RAM contents are left
// as they are, since only entries below the count are ever read.
module unique_key_record_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_key,
    input  logic [15:0] i_new_key,
    input  logic [9:0]  i_score,
    input  logic [15:0] i_slot_a,
    input  logic [15:0] i_slot_b,
    input  logic [15:0] i_slot_c,
    input  logic [15:0] i_slot_d,
    input  logic [15:0] i_slot_e,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [9:0]  o_out_score,
    output logic [15:0] o_out_slot_a,
    output logic [15:0] o_out_slot_b,
    output logic [15:0] o_out_slot_c,
    output logic [15:0] o_out_slot_d,
    output logic [15:0] o_out_slot_e,
    output logic [8:0]  o_match_count,
    output logic [6:0]  o_occupancy
);
`include "assert_macros.svh"

    localparam int AW = ukrt_pkg::AddrW;
    localparam int CW = ukrt_pkg::CntW;
    localparam int KW = ukrt_pkg::KeyW;
    localparam int SW = ukrt_pkg::ScoreW;
    localparam int LW = ukrt_pkg::SlotW;
    localparam int RW = ukrt_pkg::RecW;

    // Request registers captured at the input transfer.
    logic [2:0]       r_func;
    logic [KW-1:0]    r_key, r_nkey;
    logic [SW-1:0]    r_score;
    logic [LW-1:0]    r_in_slot [5];

    ukrt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;     // scan pointer
    logic [AW-1:0]    r_hit, n_hit;     // index of the found record
    logic             r_found, n_found;
    logic [2:0]       r_st, n_st;
    logic [RW-1:0]    r_rec, n_rec;     // record shown in the result
    logic             r_show, n_show;
    logic [8:0]       r_match, n_match;
    logic             r_valid;

    // RAM port.
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [RW-1:0]    ram_wdata, ram_rdata;

    ukrt_ram #(.Width(RW), .Depth(ukrt_pkg::Depth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Record layout: key in the top bits, then score, then slots, slot 0 lowest.
    function automatic logic [KW-1:0] rec_key(input logic [RW-1:0] r);
        rec_key = r[RW-1 -: KW];
    endfunction

    logic [SW-1:0]              cl_score;
    logic [ukrt_pkg::Slots*LW-1:0] in_slots;
    logic [RW-1:0]              new_rec;
    logic [3:0]                 hits;   // slot matches in the record read

    always_comb begin
        cl_score = (r_score > ukrt_pkg::ScoreMax) ? ukrt_pkg::ScoreMax : r_score;
        for (int s = 0; s < ukrt_pkg::Slots; s++) begin
            in_slots[s*LW +: LW] = (s < 5) ? r_in_slot[s % 5] : '0;
        end
        new_rec = {r_key, cl_score, in_slots};
        hits = '0;
        for (int s = 0; s < ukrt_pkg::Slots; s++) begin
            hits = hits + 4'((ram_rdata[s*LW +: LW] == r_in_slot[0]) ? 1 : 0);
        end
    end

    logic [9:0] match_sum;
    assign match_sum = {1'b0, r_match} + {6'd0, hits};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ukrt_pkg::S_IDLE: begin
                if (start) begin
                    priority case (ukrt_pkg::t_func'(i_func))
                        ukrt_pkg::F_NOP:   n_state = ukrt_pkg::S_DONE;
                        ukrt_pkg::F_COUNT: n_state = ukrt_pkg::S_COUNT;
                        default:           n_state = ukrt_pkg::S_SCAN;
                    endcase
                end
            end
            ukrt_pkg::S_SCAN: begin
                if (r_idx >= r_count) begin
                    priority if (!r_found) n_state = ukrt_pkg::S_DONE;
                    else n_state = ukrt_pkg::S_SCAN;
                end else begin
                    n_state = ukrt_pkg::S_SCAN_WAIT;
                end
            end
            ukrt_pkg::S_SCAN_WAIT:  n_state = ukrt_pkg::S_SCAN;
            ukrt_pkg::S_SCAN2: begin
                n_state = (r_idx >= r_count) ? ukrt_pkg::S_WRITE : ukrt_pkg::S_SCAN2_WAIT;
            end
            ukrt_pkg::S_SCAN2_WAIT: n_state = ukrt_pkg::S_SCAN2;
            ukrt_pkg::S_WRITE:      n_state = ukrt_pkg::S_DONE;
            ukrt_pkg::S_SHIFT_RD: begin
                n_state = (r_idx >= r_count) ? ukrt_pkg::S_DONE : ukrt_pkg::S_SHIFT_WAIT;
            end
            ukrt_pkg::S_SHIFT_WAIT: n_state = ukrt_pkg::S_SHIFT_WR;
            ukrt_pkg::S_SHIFT_WR:   n_state = ukrt_pkg::S_SHIFT_RD;
            ukrt_pkg::S_COUNT: begin
                n_state = (r_idx >= r_count) ? ukrt_pkg::S_DONE : ukrt_pkg::S_COUNT_WAIT;
            end
            ukrt_pkg::S_COUNT_WAIT: n_state = ukrt_pkg::S_COUNT;
            ukrt_pkg::S_DONE:       n_state = ukrt_pkg::S_IDLE;
            default:                n_state = ukrt_pkg::S_IDLE;
        endcase
    end

    // Datapath and sequencing of the scan results.
    ukrt_pkg::t_state n_state2;

    always_comb begin
        n_state2 = n_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_found  = r_found;
        n_st     = r_st;
        n_rec    = r_rec;
        n_show   = r_show;
        n_match  = r_match;
        ram_we   = 1'b0;
        ram_addr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        unique case (r_state)
            ukrt_pkg::S_IDLE: begin
                n_idx = '0; n_found = 1'b0; n_show = 1'b0; n_match = '0;
                n_st = ukrt_pkg::ST_OK;
                if (start && i_func == ukrt_pkg::F_INSERT
                        && r_count >= CW'(ukrt_pkg::Depth)) begin
                    n_st = ukrt_pkg::ST_FULL;
                    n_state2 = ukrt_pkg::S_DONE;
                end else if (start && i_func == ukrt_pkg::F_DELETE && r_count == '0) begin
                    n_st = ukrt_pkg::ST_EMPTY;
                    n_state2 = ukrt_pkg::S_DONE;
                end
            end
            ukrt_pkg::S_SCAN: begin
                if (r_idx >= r_count) begin
                    // Search done without an early exit: key absent.
                    if (r_func == ukrt_pkg::F_INSERT) begin
                        ram_we = 1'b1;
                        ram_addr = r_count[AW-1:0];
                        ram_wdata = new_rec;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_st = ukrt_pkg::ST_NOT_FOUND;
                    end
                    n_state2 = ukrt_pkg::S_DONE;
                end
            end
            ukrt_pkg::S_SCAN_WAIT: begin
                if (rec_key(ram_rdata) == r_key) begin
                    n_hit = r_idx[AW-1:0];
                    n_rec = ram_rdata;
                    n_found = 1'b1;
                    n_idx = '0;
                    unique case (ukrt_pkg::t_func'(r_func))
                        ukrt_pkg::F_INSERT: begin
                            n_st = ukrt_pkg::ST_DUP; n_state2 = ukrt_pkg::S_DONE;
                        end
                        ukrt_pkg::F_LOOKUP: begin
                            n_show = 1'b1; n_state2 = ukrt_pkg::S_DONE;
                        end
                        ukrt_pkg::F_DELETE: begin
                            n_show = 1'b1; n_idx = r_idx + 1'b1;
                            n_state2 = ukrt_pkg::S_SHIFT_RD;
                        end
                        ukrt_pkg::F_CHKEY: n_state2 = ukrt_pkg::S_SCAN2;
                        default: n_state2 = ukrt_pkg::S_WRITE;
                    endcase
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state2 = ukrt_pkg::S_SCAN;
                end
            end
            ukrt_pkg::S_SCAN2: ;
            ukrt_pkg::S_SCAN2_WAIT: begin
                if (rec_key(ram_rdata) == r_nkey) begin
                    n_st = ukrt_pkg::ST_DUP;
                    n_state2 = ukrt_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ukrt_pkg::S_WRITE: begin
                ram_we = 1'b1;
                ram_addr = r_hit;
                priority case (ukrt_pkg::t_func'(r_func))
                    ukrt_pkg::F_CHKEY: ram_wdata = {r_nkey, r_rec[RW-KW-1:0]};
                    ukrt_pkg::F_SETSC:
                        ram_wdata = {r_rec[RW-1 -: KW], cl_score, r_rec[RW-KW-SW-1:0]};
                    default: ram_wdata = {r_rec[RW-1 -: KW+SW], in_slots};
                endcase
                n_rec = ram_wdata;
                n_show = 1'b1;
            end
            ukrt_pkg::S_SHIFT_RD: begin
                if (r_idx >= r_count) n_count = r_count - 1'b1;
            end
            ukrt_pkg::S_SHIFT_WAIT: ;
            ukrt_pkg::S_SHIFT_WR: begin
                ram_we = 1'b1;
                ram_addr = AW'(r_idx - 1'b1);
                ram_wdata = ram_rdata;
                n_idx = r_idx + 1'b1;
            end
            ukrt_pkg::S_COUNT: ;
            ukrt_pkg::S_COUNT_WAIT: begin
                n_match = (match_sum > {1'b0, ukrt_pkg::MatchMax})
                        ? ukrt_pkg::MatchMax : match_sum[8:0];
                n_idx = r_idx + 1'b1;
            end
            ukrt_pkg::S_DONE: ;
            default: ;
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ukrt_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state2;
            r_count <= n_count;
            r_valid <= (r_state == ukrt_pkg::S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ukrt_pkg::S_IDLE && start) begin
            r_func       <= i_func;
            r_key        <= i_key;
            r_nkey       <= i_new_key;
            r_score      <= i_score;
            r_in_slot[0] <= i_slot_a;
            r_in_slot[1] <= i_slot_b;
            r_in_slot[2] <= i_slot_c;
            r_in_slot[3] <= i_slot_d;
            r_in_slot[4] <= i_slot_e;
        end
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_st    <= n_st;
        r_rec   <= n_rec;
        r_show  <= n_show;
        r_match <= n_match;
    end

    // Result register: loaded as the sequencer leaves its final state.
    logic [2:0]  r_o_st;
    logic [RW-1:0] r_o_rec;
    logic [8:0]  r_o_match;
    always_ff @(posedge i_clk) begin
        if (r_state == ukrt_pkg::S_DONE) begin
            r_o_st    <= r_st;
            r_o_rec   <= r_show ? r_rec : '0;
            r_o_match <= (r_func == ukrt_pkg::F_COUNT) ? r_match : '0;
        end
    end

    logic [ukrt_pkg::Slots*LW-1:0] o_slots;
    assign o_slots = r_o_rec[ukrt_pkg::Slots*LW-1:0];

    assign busy          = (r_state != ukrt_pkg::S_IDLE) || !i_rst_n;
    assign o_valid       = r_valid;
    assign o_status      = r_o_st;
    assign o_out_score   = r_o_rec[RW-KW-1 -: SW];
    assign o_out_slot_a  = o_slots[0*LW +: LW];
    assign o_out_slot_b  = o_slots[1*LW +: LW];
    assign o_out_slot_c  = o_slots[2*LW +: LW];
    assign o_out_slot_d  = o_slots[3*LW +: LW];
    assign o_out_slot_e  = o_slots[4*LW +: LW];
    assign o_match_count = r_o_match;
    assign o_occupancy   = 7'(r_count);

    `ASSERT_IMPL(a_cnt_le_depth, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(ukrt_pkg::Depth), "record count above depth")
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == ukrt_pkg::S_DONE,
        r_valid && r_state == ukrt_pkg::S_IDLE, "result not issued after done")
    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, r_valid,
        r_state == ukrt_pkg::S_IDLE, "result issued while busy")
endmodule

// File: rtl/ukrt_ram.sv
// Generic single-port RAM with registered read data.
module ukrt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: dv/unique_key_record_table_test.sv
// Self-checking testbench for the keyed record table with compacting delete.
`timescale 1ns / 100ps

module unique_key_record_table_test;

    // One operation as it is presented to the table.
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] key;
        logic [15:0] new_key;
        logic [9:0]  score;
        logic [15:0] slot_a;
        logic [15:0] slot_b;
        logic [15:0] slot_c;
        logic [15:0] slot_d;
        logic [15:0] slot_e;
    } op_t;

    // One reply of the table.
    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  score;
        logic [15:0] slot_a;
        logic [15:0] slot_b;
        logic [15:0] slot_c;
        logic [15:0] slot_d;
        logic [15:0] slot_e;
        logic [8:0]  match_count;
        logic [6:0]  occupancy;
    } reply_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [15:0] i_key;
    logic [15:0] i_new_key;
    logic [9:0]  i_score;
    logic [15:0] i_slot_a;
    logic [15:0] i_slot_b;
    logic [15:0] i_slot_c;
    logic [15:0] i_slot_d;
    logic [15:0] i_slot_e;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [9:0]  o_out_score;
    logic [15:0] o_out_slot_a;
    logic [15:0] o_out_slot_b;
    logic [15:0] o_out_slot_c;
    logic [15:0] o_out_slot_d;
    logic [15:0] o_out_slot_e;
    logic [8:0]  o_match_count;
    logic [6:0]  o_occupancy;

    unique_key_record_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_key(i_key), .i_new_key(i_new_key), .i_score(i_score),
        .i_slot_a(i_slot_a), .i_slot_b(i_slot_b), .i_slot_c(i_slot_c),
        .i_slot_d(i_slot_d), .i_slot_e(i_slot_e),
        .o_valid(o_valid), .o_status(o_status), .o_out_score(o_out_score),
        .o_out_slot_a(o_out_slot_a), .o_out_slot_b(o_out_slot_b),
        .o_out_slot_c(o_out_slot_c), .o_out_slot_d(o_out_slot_d),
        .o_out_slot_e(o_out_slot_e), .o_match_count(o_match_count),
        .o_occupancy(o_occupancy)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the table contents, kept compact from entry 0.
    logic [15:0] tbl_key   [ukrt_pkg::Depth];
    logic [9:0]  tbl_score [ukrt_pkg::Depth];
    logic [15:0] tbl_slot  [ukrt_pkg::Depth][5];
    int          tbl_count;

    op_t    pending_ops[$];
    reply_t expected_replies[$];
    int     idle_pct;
    bit     failed;

    function automatic int find_entry(logic [15:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [9:0] clamp_score(logic [9:0] v);
        return (v > ukrt_pkg::ScoreMax) ? ukrt_pkg::ScoreMax : v;
    endfunction

    // Applies one operation to the shadow table and returns the reply it must give.
    function automatic reply_t apply_op(op_t op);
        reply_t r;
        int     idx;
        int     n;
        r = '0;
        r.status = ukrt_pkg::ST_OK;
        case (ukrt_pkg::t_func'(op.func))
            ukrt_pkg::F_INSERT: begin
                if (tbl_count >= ukrt_pkg::Depth) begin
                    r.status = ukrt_pkg::ST_FULL;
                end else if (find_entry(op.key) >= 0) begin
                    r.status = ukrt_pkg::ST_DUP;
                end else begin
                    tbl_key[tbl_count]     = op.key;
                    tbl_score[tbl_count]   = clamp_score(op.score);
                    tbl_slot[tbl_count][0] = op.slot_a;
                    tbl_slot[tbl_count][1] = op.slot_b;
                    tbl_slot[tbl_count][2] = op.slot_c;
                    tbl_slot[tbl_count][3] = op.slot_d;
                    tbl_slot[tbl_count][4] = op.slot_e;
                    tbl_count++;
                end
            end
            ukrt_pkg::F_COUNT: begin
                n = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    for (int s = 0; s < 5; s++) begin
                        if (tbl_slot[i][s] == op.slot_a && n < ukrt_pkg::MatchMax) begin
                            n++;
                        end
                    end
                end
                r.match_count = 9'(n);
            end
            ukrt_pkg::F_NOP: begin
            end
            default: begin
                idx = find_entry(op.key);
                if (ukrt_pkg::t_func'(op.func) == ukrt_pkg::F_DELETE && tbl_count == 0) begin
                    r.status = ukrt_pkg::ST_EMPTY;
                end else if (idx < 0) begin
                    r.status = ukrt_pkg::ST_NOT_FOUND;
                end else if (ukrt_pkg::t_func'(op.func) == ukrt_pkg::F_CHKEY
                             && find_entry(op.new_key) >= 0) begin
                    r.status = ukrt_pkg::ST_DUP;
                end else begin
                    // Change the record first, then report it; delete reports it as it was.
                    case (ukrt_pkg::t_func'(op.func))
                        ukrt_pkg::F_CHKEY: tbl_key[idx] = op.new_key;
                        ukrt_pkg::F_SETSC: tbl_score[idx] = clamp_score(op.score);
                        ukrt_pkg::F_SETSL: begin
                            tbl_slot[idx][0] = op.slot_a;
                            tbl_slot[idx][1] = op.slot_b;
                            tbl_slot[idx][2] = op.slot_c;
                            tbl_slot[idx][3] = op.slot_d;
                            tbl_slot[idx][4] = op.slot_e;
                        end
                        default: begin
                        end
                    endcase
                    r.score  = tbl_score[idx];
                    r.slot_a = tbl_slot[idx][0];
                    r.slot_b = tbl_slot[idx][1];
                    r.slot_c = tbl_slot[idx][2];
                    r.slot_d = tbl_slot[idx][3];
                    r.slot_e = tbl_slot[idx][4];
                    if (ukrt_pkg::t_func'(op.func) == ukrt_pkg::F_DELETE) begin
                        // Later records move down one place, keeping their order.
                        for (int i = idx; i + 1 < tbl_count; i++) begin
                            tbl_key[i]   = tbl_key[i + 1];
                            tbl_score[i] = tbl_score[i + 1];
                            for (int s = 0; s < 5; s++) begin
                                tbl_slot[i][s] = tbl_slot[i + 1][s];
                            end
                        end
                        tbl_count--;
                    end
                end
            end
        endcase
        r.occupancy = 7'(tbl_count);
        return r;
    endfunction

    // Driver: on each falling edge with no transfer held, presents the next operation or idles.
    // start stays high across back-to-back transfers without dropping in between.
    always @(negedge i_clk) begin
        op_t op;
        if (i_rst_n && !(start && busy)) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
                op = pending_ops.pop_front();
                expected_replies.push_back(apply_op(op));
                start     <= 1'b1;
                i_func    <= op.func;
                i_key     <= op.key;
                i_new_key <= op.new_key;
                i_score   <= op.score;
                i_slot_a  <= op.slot_a;
                i_slot_b  <= op.slot_b;
                i_slot_c  <= op.slot_c;
                i_slot_d  <= op.slot_d;
                i_slot_e  <= op.slot_e;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed reply is checked against the oldest prediction.
    always @(posedge i_clk) begin
        reply_t got;
        reply_t want;
        if (i_rst_n && o_valid) begin
            got = {o_status, o_out_score, o_out_slot_a, o_out_slot_b, o_out_slot_c,
                   o_out_slot_d, o_out_slot_e, o_match_count, o_occupancy};
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply %h", $time, got);
                failed = 1'b1;
            end else begin
                want = expected_replies.pop_front();
                if (got.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    failed = 1'b1;
                end
                if (got.score != want.score) begin
                    $display("%0t: score expected %0d actual %0d", $time, want.score, got.score);
                    failed = 1'b1;
                end
                if (got.slot_a != want.slot_a || got.slot_b != want.slot_b ||
                    got.slot_c != want.slot_c || got.slot_d != want.slot_d ||
                    got.slot_e != want.slot_e) begin
                    $display("%0t: slots expected %h actual %h", $time,
                             {want.slot_a, want.slot_b, want.slot_c, want.slot_d, want.slot_e},
                             {got.slot_a, got.slot_b, got.slot_c, got.slot_d, got.slot_e});
                    failed = 1'b1;
                end
                if (got.match_count != want.match_count) begin
                    $display("%0t: match_count expected %0d actual %0d", $time,
                             want.match_count, got.match_count);
                    failed = 1'b1;
                end
                if (got.occupancy != want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d", $time,
                             want.occupancy, got.occupancy);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic op_t make_op(logic [2:0] f, logic [15:0] k, logic [15:0] nk,
                                    logic [9:0] sc, logic [15:0] a);
        op_t op;
        op.func    = f;
        op.key     = k;
        op.new_key = nk;
        op.score   = sc;
        op.slot_a  = a;
        op.slot_b  = 16'($urandom);
        op.slot_c  = 16'($urandom);
        op.slot_d  = 16'($urandom);
        op.slot_e  = 16'($urandom);
        return op;
    endfunction

    // Random operation. Keys come mostly from a small pool so that hits,
    // duplicates and deletes are frequent; slot values likewise so that
    // count finds matches. fill_bias favors inserts to reach a full table.
    function automatic op_t random_op(int fill_bias);
        op_t op;
        int  w;
        op = make_op(3'($urandom_range(7)), 16'($urandom_range(79)),
                     16'($urandom_range(79)), 10'($urandom_range(1023)), 16'($urandom));
        if ($urandom_range(9) == 0) begin
            op.key     = 16'($urandom);
            op.new_key = 16'($urandom);
        end
        if ($urandom_range(2) != 0) begin
            op.slot_a = 16'($urandom_range(7));
            op.slot_b = 16'($urandom_range(7));
        end
        w = $urandom_range(99);
        if (w < fill_bias) begin
            op.func = ukrt_pkg::F_INSERT;
        end else if (w < fill_bias + 8) begin
            op.func = ukrt_pkg::F_DELETE;
        end
        return op;
    endfunction

    task automatic drain();
        while (pending_ops.size() > 0 || expected_replies.size() > 0 || start) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        start     = 1'b0;
        i_func    = '0;
        i_key     = '0;
        i_new_key = '0;
        i_score   = '0;
        i_slot_a  = '0;
        i_slot_b  = '0;
        i_slot_c  = '0;
        i_slot_d  = '0;
        i_slot_e  = '0;
        tbl_count = 0;
        failed    = 1'b0;
        idle_pct  = 0;
        i_rst_n   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: operations on an empty table, extreme fields, duplicates,
        // changing a key to itself, score saturation and the no-operation code.
        pending_ops.push_back(make_op(ukrt_pkg::F_DELETE, 16'h0000, 0, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_LOOKUP, 16'hffff, 0, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_COUNT, 0, 0, 0, 16'h0000));
        pending_ops.push_back(make_op(ukrt_pkg::F_CHKEY, 16'h0001, 16'h0002, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_INSERT, 16'h0000, 0, 10'd1023, 16'hffff));
        pending_ops.push_back(make_op(ukrt_pkg::F_INSERT, 16'hffff, 0, 10'd1000, 16'h0000));
        pending_ops.push_back(make_op(ukrt_pkg::F_INSERT, 16'h0000, 0, 10'd5, 16'h0000));
        pending_ops.push_back(make_op(ukrt_pkg::F_INSERT, 16'h1234, 0, 10'd0, 16'hffff));
        pending_ops.push_back(make_op(ukrt_pkg::F_LOOKUP, 16'h0000, 0, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_CHKEY, 16'h1234, 16'h1234, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_CHKEY, 16'h1234, 16'hffff, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_CHKEY, 16'h1234, 16'h5555, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_SETSC, 16'h5555, 0, 10'd1001, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_SETSC, 16'h7777, 0, 10'd50, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_SETSL, 16'hffff, 0, 0, 16'hffff));
        pending_ops.push_back(make_op(ukrt_pkg::F_SETSL, 16'h7777, 0, 0, 16'h0001));
        pending_ops.push_back(make_op(ukrt_pkg::F_COUNT, 0, 0, 0, 16'hffff));
        pending_ops.push_back(make_op(ukrt_pkg::F_NOP, 16'hffff, 16'hffff, 10'h3ff, 16'hffff));
        pending_ops.push_back(make_op(ukrt_pkg::F_DELETE, 16'h0000, 0, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_DELETE, 16'h0000, 0, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_LOOKUP, 16'h5555, 0, 0, 0));
        drain();

        // Fill the table to capacity, then overflow it.
        for (int i = 0; i < 70; i++) begin
            pending_ops.push_back(make_op(ukrt_pkg::F_INSERT, 16'(16'h8000 + i), 0,
                                          10'($urandom_range(1023)), 16'h0003));
        end
        pending_ops.push_back(make_op(ukrt_pkg::F_COUNT, 0, 0, 0, 16'h0003));
        pending_ops.push_back(make_op(ukrt_pkg::F_DELETE, 16'h8000, 0, 0, 0));
        pending_ops.push_back(make_op(ukrt_pkg::F_DELETE, 16'h803f, 0, 0, 0));
        drain();

        // Random phases with varied idling; the drain between phases is the
        // pause until every expected reply has arrived.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 62;
                2: idle_pct = 12;
                default: idle_pct = 0;
            endcase
            for (int i = 0; i < 280; i++) begin
                pending_ops.push_back(random_op(ph == 3 ? 60 : 25));
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (expected_replies.size() > 0) begin
            failed = 1'b1;
        end
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Roughly 1200 items, with idling, fit well inside this timeout.
    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
